[hdl/ledfl_pkg.sv]
// ----------------------------------------------------------------------------
// ledfl_pkg
// Types, action codes and digit encoding for the LED flash/timeout display
// controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ledfl_pkg;

    localparam logic [2:0] ACT_TICK       = 3'd0;
    localparam logic [2:0] ACT_PROGRAM    = 3'd1;
    localparam logic [2:0] ACT_COLOURS    = 3'd2;
    localparam logic [2:0] ACT_FLASH      = 3'd3;
    localparam logic [2:0] ACT_TIMED_SHOW = 3'd4;
    localparam logic [2:0] ACT_CLEAR      = 3'd5;

    localparam logic [7:0] MASK_ROTENC = 8'b0000_0011;
    localparam logic [7:0] MASK_PROG   = 8'b1111_1100;
    localparam logic [3:0] MAX_SPEED   = 4'd14;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] now;
        logic [5:0]  program_req;
        logic        orange;
        logic        blue;
        logic [7:0]  leds;
        logic [3:0]  speed;
        logic [7:0]  repeats;
        logic [15:0] duration;
    } t_in_item;

    typedef struct packed {
        logic       shift_valid;
        logic [7:0] pattern;
        logic       clear_pulse;
        logic       flashing;
        logic       timed_showing;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  display_bits;
        logic        flash_active;
        logic [15:0] flash_start_time;
        logic [7:0]  flash_pattern;
        logic [7:0]  flash_toggle_mask;
        logic        flash_phase;
        logic [3:0]  flash_rate;
        logic [7:0]  flash_remaining;
        logic        timed_active;
        logic [15:0] timed_start_time;
        logic [15:0] timed_length;
    } t_state;

    // Low program digit lands on bits 7, 5, 3.
    function automatic logic [7:0] lo_digit(input logic [2:0] d);
        lo_digit = {d[0], 1'b0, d[1], 1'b0, d[2], 3'b000};
    endfunction

    // High program digit lands on bits 6, 4, 2.
    function automatic logic [7:0] hi_digit(input logic [2:0] d);
        hi_digit = {1'b0, d[0], 1'b0, d[1], 1'b0, d[2], 2'b00};
    endfunction

endpackage

`default_nettype wire

[hdl/ledfl_step.sv]
// ----------------------------------------------------------------------------
// ledfl_step
// Next-state and result logic for one event, applied to the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module ledfl_step (
    input  wire  ledfl_pkg::t_in_item  i_item,
    input  wire  ledfl_pkg::t_state    i_state,
    output ledfl_pkg::t_state          o_state,
    output ledfl_pkg::t_out_item       o_result
);
    import ledfl_pkg::*;

    logic [15:0] w_flash_elapsed;
    logic [15:0] w_timed_elapsed;
    logic [3:0]  w_bit_idx;
    logic        w_phase;
    logic [7:0]  w_new_prog;
    logic [7:0]  w_new_col;
    logic [7:0]  w_toggled;
    logic        w_quiet;
    t_state      w_st;
    logic        w_valid;
    logic        w_pulse;
    logic [7:0]  w_byte;

    assign w_flash_elapsed = i_item.now - i_state.flash_start_time;
    assign w_timed_elapsed = i_item.now - i_state.timed_start_time;
    assign w_bit_idx       = MAX_SPEED - i_state.flash_rate;
    assign w_phase         = w_flash_elapsed[w_bit_idx];
    assign w_new_prog      = lo_digit(i_item.program_req[2:0])
                           | hi_digit(i_item.program_req[5:3]);
    assign w_new_col       = {6'b0, i_item.blue, i_item.orange};
    assign w_toggled       = i_state.flash_pattern ^ i_state.flash_toggle_mask;
    assign w_quiet         = !i_state.flash_active && !i_state.timed_active;

    always_comb begin
        w_st    = i_state;
        w_valid = 1'b0;
        w_pulse = 1'b0;
        w_byte  = 8'd0;
        unique case (i_item.action)
            ACT_TICK: begin
                if (i_state.flash_active) begin
                    if (w_phase != i_state.flash_phase) begin
                        if (i_state.flash_remaining == 8'd1) begin
                            w_st.flash_active = 1'b0;
                            w_byte            = i_state.display_bits;
                        end else begin
                            w_st.flash_pattern = w_toggled;
                            w_byte             = w_toggled;
                        end
                        w_valid = 1'b1;
                        if (i_state.flash_remaining != 8'd0) begin
                            w_st.flash_remaining = i_state.flash_remaining - 8'd1;
                        end
                        w_st.flash_phase = w_phase;
                    end
                end else if (i_state.timed_active) begin
                    if (w_timed_elapsed > i_state.timed_length) begin
                        w_byte            = i_state.display_bits;
                        w_valid           = 1'b1;
                        w_st.timed_active = 1'b0;
                    end
                end
            end
            ACT_PROGRAM: begin
                if (w_new_prog != (i_state.display_bits & MASK_PROG)) begin
                    w_st.display_bits = (i_state.display_bits & MASK_ROTENC) | w_new_prog;
                    if (w_quiet) begin
                        w_byte  = w_st.display_bits;
                        w_valid = 1'b1;
                    end
                end
            end
            ACT_COLOURS: begin
                if (w_new_col != (i_state.display_bits & MASK_ROTENC)) begin
                    w_st.display_bits = (i_state.display_bits & MASK_PROG) | w_new_col;
                    if (w_quiet) begin
                        w_byte  = w_st.display_bits;
                        w_valid = 1'b1;
                    end
                end
            end
            ACT_FLASH: begin
                w_st.flash_active      = 1'b1;
                w_st.flash_toggle_mask = i_item.leds;
                w_st.flash_pattern     = i_state.display_bits ^ i_item.leds;
                w_st.flash_remaining   = i_item.repeats;
                w_st.flash_start_time  = i_item.now;
                w_st.flash_rate        = (i_item.speed > MAX_SPEED) ? MAX_SPEED
                                                                    : i_item.speed;
                w_st.flash_phase       = 1'b0;
                w_byte                 = i_state.display_bits ^ i_item.leds;
                w_valid                = 1'b1;
            end
            ACT_TIMED_SHOW: begin
                w_st.timed_active     = 1'b1;
                w_st.timed_start_time = i_item.now;
                w_st.timed_length     = i_item.duration;
                w_byte                = i_item.leds;
                w_valid               = 1'b1;
            end
            ACT_CLEAR: begin
                w_byte            = i_state.display_bits;
                w_valid           = 1'b1;
                w_pulse           = 1'b1;
                w_st.display_bits = 8'd0;
                w_st.flash_active = 1'b0;
                w_st.timed_active = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_state                = w_st;
    assign o_result.shift_valid   = w_valid;
    assign o_result.pattern       = w_byte;
    assign o_result.clear_pulse   = w_pulse;
    assign o_result.flashing      = w_st.flash_active;
    assign o_result.timed_showing = w_st.timed_active;

endmodule

`default_nettype wire

[hdl/led_flash_timeout_display_controller_unit.sv]
// ----------------------------------------------------------------------------
// led_flash_timeout_display_controller_unit
// Event-driven controller for an 8-LED shift-register display.
// ----------------------------------------------------------------------------
// Path: an event is taken into the input register, and its result is written
// to the result register once that register is free or draining.
// Throughput: one event per cycle while the output is not stalled; the state
// update is a single pass of compare/subtract logic between the two registers.
// Reset: synchronous, active low; clears both stage valids and all state.
`default_nettype none

module led_flash_timeout_display_controller_unit (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire  ledfl_pkg::t_in_item  i_in_item,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output ledfl_pkg::t_out_item       o_out_item
);
    import ledfl_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_state    r_state;
    t_state    n_state;
    t_out_item n_out_item;
    logic      w_advance;

    // The input stage moves on when the result register is free or draining.
    assign w_advance  = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || w_advance;

    ledfl_step u_step (
        .i_item   (r_in_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A held input item must not be overwritten or dropped.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_item))
        else $error("input stage lost or changed a held item");

    // A reset pulse always comes with a shifted byte.
    a_pulse_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.clear_pulse |-> o_out_item.shift_valid)
        else $error("clear pulse without shift");

    // Nothing shifted means a zero byte.
    a_idle_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.shift_valid |-> o_out_item.pattern == 8'd0)
        else $error("pattern nonzero without shift");

    // Clear ends both the flash and the timed show.
    a_clear_modes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.clear_pulse
            |-> !o_out_item.flashing && !o_out_item.timed_showing)
        else $error("mode still active after clear");

endmodule

`default_nettype wire

[bench/led_flash_timeout_display_controller_unit_test.sv]
// ----------------------------------------------------------------------------
// led_flash_timeout_display_controller_unit_test
// Self-checking bench for the LED flash/timeout display controller. Events go
// in over a valid/ready channel and a local model of the display state
// predicts each shifted byte and flag set. Directed events cover the edge
// cases. Random runs of flashes, timed shows and mixed traffic follow, under
// three idle patterns on the two channels.
// ----------------------------------------------------------------------------
`default_nettype none

module led_flash_timeout_display_controller_unit_test;
    import ledfl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_LIMIT = 20000;

    logic      i_clk;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_ready = 1'b0;
    wire       o_in_ready;
    wire       o_out_valid;
    t_out_item o_out_item;

    led_flash_timeout_display_controller_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    t_state      mirror_state = '0;
    t_out_item   expected_shifts[$];
    t_out_item   want_item;
    logic [15:0] clock_ticks = '0;
    int          sent_events = 0;
    int          mismatch_count = 0;
    int          sender_idle_pct = 0;
    int          receiver_idle_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------- model
    function automatic logic [7:0] encode_program(input logic [5:0] prog);
        logic [7:0] lo;
        logic [7:0] hi;
        case (prog[2:0])
            3'd0: lo = 8'h00;
            3'd1: lo = 8'h80;
            3'd2: lo = 8'h20;
            3'd3: lo = 8'hA0;
            3'd4: lo = 8'h08;
            3'd5: lo = 8'h88;
            3'd6: lo = 8'h28;
            default: lo = 8'hA8;
        endcase
        case (prog[5:3])
            3'd0: hi = 8'h00;
            3'd1: hi = 8'h40;
            3'd2: hi = 8'h10;
            3'd3: hi = 8'h50;
            3'd4: hi = 8'h04;
            3'd5: hi = 8'h44;
            3'd6: hi = 8'h14;
            default: hi = 8'h54;
        endcase
        return lo | hi;
    endfunction

    function automatic t_out_item predict_led_event(input t_in_item ev);
        t_out_item   res;
        logic [15:0] elapsed;
        logic [3:0]  bit_sel;
        logic        phase;
        logic [7:0]  new_bits;
        res = '0;
        case (ev.action)
            ACT_TICK: begin
                if (mirror_state.flash_active) begin
                    elapsed = ev.now - mirror_state.flash_start_time;
                    bit_sel = MAX_SPEED - mirror_state.flash_rate;
                    phase   = elapsed[bit_sel];
                    if (phase != mirror_state.flash_phase) begin
                        if (mirror_state.flash_remaining == 8'd1) begin
                            mirror_state.flash_active = 1'b0;
                            res.pattern = mirror_state.display_bits;
                        end else begin
                            mirror_state.flash_pattern = mirror_state.flash_pattern
                                                    ^ mirror_state.flash_toggle_mask;
                            res.pattern = mirror_state.flash_pattern;
                        end
                        res.shift_valid = 1'b1;
                        if (mirror_state.flash_remaining != 8'd0)
                            mirror_state.flash_remaining = mirror_state.flash_remaining
                                                         - 8'd1;
                        mirror_state.flash_phase = phase;
                    end
                end else if (mirror_state.timed_active) begin
                    elapsed = ev.now - mirror_state.timed_start_time;
                    if (elapsed > mirror_state.timed_length) begin
                        res.pattern          = mirror_state.display_bits;
                        res.shift_valid      = 1'b1;
                        mirror_state.timed_active = 1'b0;
                    end
                end
            end
            ACT_PROGRAM: begin
                new_bits = encode_program(ev.program_req);
                if (new_bits != (mirror_state.display_bits & MASK_PROG)) begin
                    mirror_state.display_bits = (mirror_state.display_bits & MASK_ROTENC)
                                              | new_bits;
                    if (!mirror_state.flash_active && !mirror_state.timed_active) begin
                        res.pattern     = mirror_state.display_bits;
                        res.shift_valid = 1'b1;
                    end
                end
            end
            ACT_COLOURS: begin
                new_bits = {6'd0, ev.blue, ev.orange};
                if (new_bits != (mirror_state.display_bits & MASK_ROTENC)) begin
                    mirror_state.display_bits = (mirror_state.display_bits & MASK_PROG)
                                              | new_bits;
                    if (!mirror_state.flash_active && !mirror_state.timed_active) begin
                        res.pattern     = mirror_state.display_bits;
                        res.shift_valid = 1'b1;
                    end
                end
            end
            ACT_FLASH: begin
                mirror_state.flash_active      = 1'b1;
                mirror_state.flash_toggle_mask = ev.leds;
                mirror_state.flash_pattern     = mirror_state.display_bits ^ ev.leds;
                mirror_state.flash_remaining   = ev.repeats;
                mirror_state.flash_start_time  = ev.now;
                mirror_state.flash_rate        = (ev.speed > MAX_SPEED) ? MAX_SPEED
                                                                        : ev.speed;
                mirror_state.flash_phase       = 1'b0;
                res.pattern     = mirror_state.flash_pattern;
                res.shift_valid = 1'b1;
            end
            ACT_TIMED_SHOW: begin
                mirror_state.timed_active     = 1'b1;
                mirror_state.timed_start_time = ev.now;
                mirror_state.timed_length     = ev.duration;
                res.pattern     = ev.leds;
                res.shift_valid = 1'b1;
            end
            ACT_CLEAR: begin
                res.pattern     = mirror_state.display_bits;
                res.shift_valid = 1'b1;
                res.clear_pulse = 1'b1;
                mirror_state.display_bits = '0;
                mirror_state.flash_active = 1'b0;
                mirror_state.timed_active = 1'b0;
            end
            default: ;
        endcase
        res.flashing      = mirror_state.flash_active;
        res.timed_showing = mirror_state.timed_active;
        return res;
    endfunction

    // --------------------------------------------------------------- driving
    function automatic t_in_item random_event(input logic [2:0] act);
        logic [63:0] raw;
        t_in_item    ev;
        raw       = {$urandom, $urandom};
        ev        = raw[62:0];
        ev.action = act;
        ev.now    = clock_ticks;
        return ev;
    endfunction

    function automatic t_in_item plain_event(input logic [2:0] act, input logic [15:0] at);
        t_in_item ev;
        ev        = '0;
        ev.action = act;
        ev.now    = at;
        return ev;
    endfunction

    // Entered and left at a falling edge.
    task automatic send_event(input t_in_item ev);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= ev;
        do @(posedge i_clk); while (!o_in_ready);
        expected_shifts.push_back(predict_led_event(ev));
        sent_events++;
        @(negedge i_clk);
    endtask

    always @(negedge i_clk)
        out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);

    // --------------------------------------------------------------- checking
    task automatic report_mismatch(input string what, input t_out_item exp_item,
                                   input t_out_item got_item);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s: expected valid=%0b pattern=%02h clear=%0b flash=%0b timed=%0b",
                     $realtime, what,
                     exp_item.shift_valid, exp_item.pattern, exp_item.clear_pulse,
                     exp_item.flashing, exp_item.timed_showing);
            $display("    got valid=%0b pattern=%02h clear=%0b flash=%0b timed=%0b",
                     got_item.shift_valid, got_item.pattern, got_item.clear_pulse,
                     got_item.flashing, got_item.timed_showing);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_shifts.size() == 0) begin
                report_mismatch("unexpected result", '0, o_out_item);
            end else begin
                want_item = expected_shifts.pop_front();
                if (o_out_item.shift_valid   !== want_item.shift_valid   ||
                    o_out_item.pattern       !== want_item.pattern       ||
                    o_out_item.clear_pulse   !== want_item.clear_pulse   ||
                    o_out_item.flashing      !== want_item.flashing      ||
                    o_out_item.timed_showing !== want_item.timed_showing)
                    report_mismatch("result mismatch", want_item, o_out_item);
            end
        end
    end

    // ------------------------------------------------------------------ tests
    task automatic test_directed_events();
        t_in_item ev;
        send_event(plain_event(ACT_TICK, 16'd0));
        send_event(plain_event(ACT_PROGRAM, 16'd0));        // no change, no shift
        ev = plain_event(ACT_PROGRAM, 16'd0);
        ev.program_req = 6'd63;
        send_event(ev);
        ev.program_req = 6'h2A;
        send_event(ev);
        send_event(ev);                                     // repeat, no shift
        ev = plain_event(ACT_COLOURS, 16'd0);
        ev.orange = 1'b1;
        send_event(ev);
        ev.blue = 1'b1;
        send_event(ev);
        send_event(ev);
        ev = '1;
        ev.action = 3'd6;
        send_event(ev);
        ev.action = 3'd7;
        send_event(ev);
        // Speed above range saturates, so bit 0 of elapsed time toggles.
        ev = plain_event(ACT_FLASH, 16'h1234);
        ev.leds    = 8'hFF;
        ev.speed   = 4'd15;
        ev.repeats = 8'd2;
        send_event(ev);
        send_event(plain_event(ACT_TICK, 16'h1234));
        send_event(plain_event(ACT_TICK, 16'h1235));
        ev = plain_event(ACT_PROGRAM, 16'h1235);
        ev.program_req = 6'd5;
        send_event(ev);                                     // hidden while flashing
        send_event(plain_event(ACT_TICK, 16'h1236));        // last repeat ends flash
        // Endless flash at the slowest speed, elapsed time wrapping.
        ev = plain_event(ACT_FLASH, 16'hFFF0);
        ev.leds = 8'h55;
        send_event(ev);
        send_event(plain_event(ACT_TICK, 16'h3FF0));
        ev = plain_event(ACT_TIMED_SHOW, 16'd100);
        ev.leds = 8'hC3;
        send_event(ev);                                     // flash keeps priority
        send_event(plain_event(ACT_CLEAR, 16'd100));
        ev = plain_event(ACT_TIMED_SHOW, 16'hFFFF);
        ev.duration = 16'hFFFF;
        send_event(ev);
        send_event(plain_event(ACT_TICK, 16'hFFFE));
        ev = plain_event(ACT_TIMED_SHOW, 16'd50);
        ev.leds     = 8'h81;
        ev.duration = 16'd10;
        send_event(ev);
        send_event(plain_event(ACT_TICK, 16'd60));          // equal, still shown
        send_event(plain_event(ACT_TICK, 16'd61));          // past, show ends
        send_event(plain_event(ACT_CLEAR, 16'd61));
    endtask

    task automatic test_flash_runs(input int count);
        t_in_item ev;
        int       stop_at;
        int       ticks;
        int       half;
        logic [3:0] rate;
        stop_at = sent_events + count;
        while (sent_events < stop_at) begin
            clock_ticks += 16'($urandom_range(0, 65535));
            ev = random_event(ACT_FLASH);
            if ($urandom_range(0, 3) != 0)
                ev.repeats = 8'($urandom_range(0, 6));
            send_event(ev);
            rate  = (ev.speed > MAX_SPEED) ? MAX_SPEED : ev.speed;
            half  = 1 << (MAX_SPEED - rate);
            ticks = $urandom_range(2, 14);
            for (int k = 0; k < ticks; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    ev = random_event($urandom_range(0, 1) ? ACT_PROGRAM : ACT_COLOURS);
                end else begin
                    clock_ticks += 16'($urandom_range(0, 2 * half));
                    ev = random_event(ACT_TICK);
                end
                send_event(ev);
            end
        end
    endtask

    task automatic test_timed_runs(input int count);
        t_in_item ev;
        int       stop_at;
        int       ticks;
        int       span;
        stop_at = sent_events + count;
        while (sent_events < stop_at) begin
            // Drop a running flash most of the time so the timeout is visible.
            if (mirror_state.flash_active && $urandom_range(0, 3) != 0)
                send_event(random_event(ACT_CLEAR));
            clock_ticks += 16'($urandom_range(0, 65535));
            ev = random_event(ACT_TIMED_SHOW);
            if ($urandom_range(0, 2) != 0)
                ev.duration = 16'($urandom_range(0, 64));
            send_event(ev);
            span  = int'(ev.duration) / 3 + 2;
            ticks = $urandom_range(2, 10);
            for (int k = 0; k < ticks; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    ev = random_event($urandom_range(0, 1) ? ACT_PROGRAM : ACT_COLOURS);
                end else begin
                    clock_ticks += 16'($urandom_range(0, span));
                    ev = random_event(ACT_TICK);
                end
                send_event(ev);
            end
        end
    endtask

    task automatic test_mixed_traffic(input int count);
        t_in_item ev;
        int       stop_at;
        stop_at = sent_events + count;
        while (sent_events < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1: ev = random_event(ACT_PROGRAM);
                2, 3: ev = random_event(ACT_COLOURS);
                4:    ev = random_event(ACT_CLEAR);
                5:    ev = random_event(ACT_FLASH);
                6:    ev = random_event(ACT_TIMED_SHOW);
                7: begin
                    clock_ticks += 16'($urandom_range(0, 65535));
                    ev = random_event(ACT_TICK);
                end
                default: begin
                    ev = random_event(3'($urandom_range(0, 7)));
                    ev.now = 16'($urandom);
                end
            endcase
            send_event(ev);
        end
    endtask

    // Hold the sender until every outstanding result has come back.
    task automatic test_pause_until_drained();
        in_valid <= 1'b0;
        while (expected_shifts.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct);
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        test_flash_runs(130);
        test_timed_runs(120);
        test_mixed_traffic(130);
        test_pause_until_drained();
    endtask

    initial begin
        int waited;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        sender_idle_pct   = 37;
        receiver_idle_pct = 54;
        test_directed_events();
        test_pause_until_drained();
        run_random_phase(37, 54);
        run_random_phase(54, 37);
        run_random_phase(0, 0);

        in_valid <= 1'b0;
        waited = 0;
        while (expected_shifts.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_shifts.size() != 0) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            repeat (8) @(posedge i_clk);
            if (mismatch_count == 0)
                $display("Test completed successfully");
            else
                $display("Test completed with failures");
            $finish;
        end
    end

endmodule

`default_nettype wire
